### src/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg
// Types and constants shared by the stream decoder modules.
// ----------------------------------------------------------------------------
package hsd_pkg;

  localparam int unsigned NodeSlots  = 512;
  localparam int unsigned StackDepth = 256;
  localparam int unsigned CountBits  = 32;

  localparam int unsigned NodeW  = $clog2(NodeSlots);
  localparam int unsigned StackW = $clog2(StackDepth);

  localparam logic [7:0] CharI    = 8'h49;
  localparam logic [7:0] CharL    = 8'h4C;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  localparam logic [CountBits-1:0] CountMax = '1;

  localparam logic [1:0] PhHeader = 2'd0;
  localparam logic [1:0] PhTree   = 2'd1;
  localparam logic [1:0] PhData   = 2'd2;
  localparam logic [1:0] PhDone   = 2'd3;

  typedef struct packed {
    logic       start_req;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
    logic       status;
  } out_word_t;

  // node table entry: leaf flag, symbol, left, right
  typedef struct packed {
    logic             is_leaf;
    logic [7:0]       sym;
    logic [NodeW-1:0] left;
    logic [NodeW-1:0] right;
  } node_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic             left_done;
  } stk_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input word, apply start
    logic tree_op;  // perform one tree-phase step
    logic bit_rd;   // issue node read for walk
    logic bit_use;  // consume read data for current bit
  } hsd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] phase;
    logic       bits_done;
    logic       emit;
  } hsd_sts_t;

endpackage

### src/hsd_ctrl.sv
// ----------------------------------------------------------------------------
// hsd_ctrl
// Sequencer: take a word, run a tree step or up to eight bit walk steps.
// ----------------------------------------------------------------------------
module hsd_ctrl import hsd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     out_busy_i,
  input  hsd_sts_t sts_i,
  output hsd_cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDisp = 2'd1;
  localparam logic [1:0] StRead = 2'd2;
  localparam logic [1:0] StUse  = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDisp;
        end
      end
      StDisp: begin
        priority if (sts_i.phase == PhData) begin
          cmd_o.bit_rd = 1'b1;
          state_d      = StRead;
        end else if (!out_busy_i) begin
          cmd_o.tree_op = 1'b1;
          state_d       = StIdle;
        end else begin
          // hold until the output register drains
          state_d = StDisp;
        end
      end
      StRead: state_d = StUse;
      StUse: begin
        // hold while a symbol would overrun the output register
        if (!(sts_i.emit && out_busy_i)) begin
          cmd_o.bit_use = 1'b1;
          state_d       = StDisp;
          if (sts_i.bits_done) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/hsd_dpath.sv
// ----------------------------------------------------------------------------
// hsd_dpath
// Count, tree build stack, node table and walk datapath.
// ----------------------------------------------------------------------------
module hsd_dpath import hsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  hsd_cmd_t  cmd_i,
  output hsd_sts_t  sts_o,
  output logic      res_valid_o,
  output out_word_t res_o
);

  node_t mem_q [NodeSlots];
  stk_t  stk_q [StackDepth];

  logic [1:0]           phase_q, phase_d;
  logic [CountBits-1:0] left_q, left_d;
  logic                 pend_q, pend_d;
  logic [NodeW:0]       nfree_q, nfree_d;
  logic [StackW:0]      depth_q, depth_d;
  logic [NodeW-1:0]     walk_q, walk_d;
  logic [7:0]           byte_q, byte_d;
  logic [2:0]           bit_q, bit_d;
  logic                 fin_q, fin_d;
  logic                 res_valid_d;
  out_word_t            res_d;
  node_t                rd_q;
  stk_t                 top_q;
  logic                 rd_child_q;
  logic [NodeW-1:0]     child_q;

  // ---- header digit accumulate (saturating) ----
  logic [3:0]           dig;
  logic                 is_digit;
  logic [CountBits+4:0] prod;
  assign dig      = 4'(in_word_i.data_byte - CharZero);
  assign is_digit = (in_word_i.data_byte >= CharZero) && (in_word_i.data_byte <= CharNine);
  assign prod = ({5'd0, left_q} << 3) + ({5'd0, left_q} << 1) + (CountBits+5)'(dig);

  // ---- tree step decode ----
  logic                 is_leaf;
  logic                 err;
  logic [NodeW-1:0]     idx;
  logic                 tree_add;
  logic                 fix_parent;
  logic                 stk_fix_we;
  logic                 stk_push_we;
  logic [StackW-1:0]    stk_fix_a;
  logic [StackW-1:0]    stk_push_a;
  logic [StackW:0]      depth_mid;
  assign is_leaf = pend_q;
  assign idx     = nfree_q[NodeW-1:0];
  always_comb begin
    err = 1'b0;
    if (nfree_q >= (NodeW+1)'(NodeSlots)) err = 1'b1;
    if (!is_leaf && depth_q >= (StackW+1)'(StackDepth)) err = 1'b1;
  end

  assign tree_add = cmd_i.tree_op && phase_q == PhTree && !err &&
                    !(!pend_q && byte_q == CharL);

  // ---- walk decode ----
  logic             cur_bit;
  logic [NodeW-1:0] rd_addr;
  assign cur_bit = byte_q[3'd7 - bit_q];
  assign rd_addr = cur_bit ? rd_q.right : rd_q.left;

  assign sts_o.phase     = phase_q;
  assign sts_o.bits_done = (bit_q == 3'd7) || (left_q == '0) || fin_q;
  assign sts_o.emit      = rd_q.is_leaf && (left_q != '0) && !fin_q;

  // stack update: mark the parent's left child done, or pop it after its right
  assign fix_parent  = (depth_q != '0);
  assign stk_fix_a   = StackW'(depth_q - 1'b1);
  assign stk_push_we = tree_add && !is_leaf;
  assign stk_push_a  = depth_mid[StackW-1:0];
  always_comb begin
    depth_mid  = depth_q;
    stk_fix_we = 1'b0;
    if (tree_add && fix_parent) begin
      if (!top_q.left_done) stk_fix_we = 1'b1;
      else                  depth_mid  = depth_q - 1'b1;
    end
  end

  // first read of a bit step fetches the current node; second the child
  always_ff @(posedge clk_i) begin
    if (cmd_i.bit_rd) begin
      rd_q       <= mem_q[walk_q];
      rd_child_q <= 1'b0;
    end else if (!rd_child_q && phase_q == PhData && !cmd_i.bit_use) begin
      rd_q       <= mem_q[rd_addr];
      rd_child_q <= 1'b1;
      child_q    <= rd_addr;
    end
    if (tree_add) begin
      mem_q[idx] <= '{is_leaf: is_leaf, sym: is_leaf ? byte_q : 8'd0,
                      left: '0, right: '0};
      if (fix_parent) begin
        if (!top_q.left_done) mem_q[top_q.node].left <= idx;
        else                  mem_q[top_q.node].right <= idx;
      end
    end
    if (cmd_i.load) top_q <= (depth_q != '0) ? stk_q[StackW'(depth_q - 1'b1)] : '0;
    if (stk_fix_we)  stk_q[stk_fix_a]  <= '{node: top_q.node, left_done: 1'b1};
    if (stk_push_we) stk_q[stk_push_a] <= '{node: idx, left_done: 1'b0};
  end

  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    pend_d      = pend_q;
    nfree_d     = nfree_q;
    depth_d     = depth_q;
    walk_d      = walk_q;
    byte_d      = byte_q;
    bit_d       = bit_q;
    fin_d       = fin_q;
    res_valid_d = 1'b0;
    res_d       = res_o;
    if (cmd_i.load) begin
      byte_d = in_word_i.data_byte;
      bit_d  = '0;
      fin_d  = 1'b0;
      if (in_word_i.start_req) begin
        left_d  = '0;
        pend_d  = 1'b0;
        nfree_d = '0;
        depth_d = '0;
        walk_d  = '0;
      end
      // header processing is immediate
      priority if (in_word_i.start_req || phase_q == PhHeader) begin
        phase_d = PhHeader;
        if (is_digit) begin
          if (in_word_i.start_req) left_d = CountBits'(dig);
          else if (prod[CountBits+4:CountBits] != '0) left_d = CountMax;
          else left_d = prod[CountBits-1:0];
        end else if (in_word_i.data_byte == CharL || in_word_i.data_byte == CharI) begin
          // the tree step takes this byte: an 'L' only marks a pending leaf
          phase_d = PhTree;
          pend_d  = 1'b0;
        end
      end else if (phase_q == PhData && left_q == '0) begin
        phase_d = PhDone;
      end else begin
        phase_d = phase_q;
      end
    end
    if (cmd_i.tree_op && phase_q == PhTree) begin
      if (!pend_q && byte_q == CharL) begin
        pend_d = 1'b1;
      end else if (err) begin
        phase_d     = PhDone;
        res_valid_d = 1'b1;
        res_d       = '{symbol: 8'd0, last: 1'b1, status: 1'b1};
      end else begin
        pend_d  = 1'b0;
        nfree_d = nfree_q + 1'b1;
        depth_d = is_leaf ? depth_mid : depth_mid + 1'b1;
        if (is_leaf && depth_mid == '0) begin
          if (idx == '0) begin
            phase_d     = PhDone;
            res_valid_d = 1'b1;
            res_d       = '{symbol: 8'd0, last: 1'b1, status: 1'b1};
          end else begin
            phase_d = PhData;
            walk_d  = '0;
          end
        end
      end
    end
    if (cmd_i.bit_use) begin
      bit_d = bit_q + 1'b1;
      if (left_q == '0 || fin_q) begin
        fin_d   = 1'b1;
        phase_d = PhDone;
      end else if (rd_q.is_leaf) begin
        left_d      = left_q - 1'b1;
        res_valid_d = 1'b1;
        res_d       = '{symbol: rd_q.sym, last: (left_q == CountBits'(1)), status: 1'b0};
        walk_d      = '0;
        if (left_q == CountBits'(1)) phase_d = PhDone;
      end else begin
        walk_d = child_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      left_q      <= '0;
      pend_q      <= 1'b0;
      nfree_q     <= '0;
      depth_q     <= '0;
      walk_q      <= '0;
      byte_q      <= '0;
      bit_q       <= '0;
      fin_q       <= 1'b0;
      res_valid_o <= 1'b0;
      res_o       <= '0;
    end else begin
      phase_q     <= phase_d;
      left_q      <= left_d;
      pend_q      <= pend_d;
      nfree_q     <= nfree_d;
      depth_q     <= depth_d;
      walk_q      <= walk_d;
      byte_q      <= byte_d;
      bit_q       <= bit_d;
      fin_q       <= fin_d;
      res_valid_o <= res_valid_d;
      res_o       <= res_d;
    end
  end

endmodule

### src/huffman_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// huffman_stream_decoder_top
// Byte-serial decoder for a count + preorder tree + packed code stream.
// ----------------------------------------------------------------------------
//  port      dir  word
//  in_*      in   start_req, data_byte
//  out_*     out  symbol, last, status
//
//  Header and tree bytes are accepted, then take one tree step. A data byte
//  is accepted, then each code bit is a dispatch with node read, a child read
//  and a consume, for up to eight bits; fewer once the count runs out.
//  Two dependent node table reads per code bit bound the walk rate.
//  Reset clears all control state; the node table and stack need no clear.
//  A symbol or tree step waits while out_stall_i holds a result in the output
//  register, and in_stall_o stays high until the byte is finished.
module huffman_stream_decoder_top import hsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  hsd_cmd_t  cmd;
  hsd_sts_t  sts;
  logic      res_valid;
  out_word_t res;

  hsd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_busy_i (out_valid_o && out_stall_i),
    .sts_i (sts), .cmd_o (cmd)
  );

  hsd_dpath u_dpath (
    .clk_i, .rst_ni, .in_word_i (in_data_i), .cmd_i (cmd), .sts_o (sts),
    .res_valid_o (res_valid), .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      out_data_o  <= '0;
    end else begin
      if (res_valid) begin
        out_valid_o <= 1'b1;
        out_data_o  <= res;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !res_valid) else $error("result overrun");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |-> out_data_o.last) else $error("error not last");
`endif

endmodule

### tb/sv/huffman_stream_decoder_top_test.sv
// ----------------------------------------------------------------------------
// huffman_stream_decoder_top_test
// Feeds whole compressed files (count, preorder tree, code bits) plus noise
// and broken files through the decoder and checks every symbol it returns.
// ----------------------------------------------------------------------------
module huffman_stream_decoder_top_test;
  import hsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_data_o;

  huffman_stream_decoder_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // decoder state kept alongside the block
  logic [1:0]           dec_phase;
  logic [CountBits-1:0] dec_left;
  logic                 dec_leaf_pend;
  node_t                dec_nodes [NodeSlots];
  int unsigned          dec_free;
  stk_t                 dec_stack [StackDepth];
  int unsigned          dec_depth;
  int unsigned          dec_walk;

  in_word_t  pending_words [$];
  out_word_t expected_syms [$];
  int        error_count;
  int        words_sent;
  int        syms_seen;
  bit        quiet_tail;
  bit        hold_off_req;

  // tree builder scratch for stimulus
  logic [7:0] code_bits [256][$];
  logic [7:0] leaf_syms [$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input out_word_t got, input out_word_t exp);
    $display("MISMATCH %s: got sym=%02h last=%0b st=%0b exp sym=%02h last=%0b st=%0b",
             what, got.symbol, got.last, got.status, exp.symbol, exp.last, exp.status);
    error_count++;
  endtask

  function automatic out_word_t error_word();
    out_word_t w;
    w.symbol = 8'h00;
    w.last   = 1'b1;
    w.status = 1'b1;
    dec_phase = PhDone;
    return w;
  endfunction

  function automatic bit decoder_add_node(input bit leaf, input logic [7:0] sym);
    int unsigned idx;
    if (dec_free >= NodeSlots) return 1'b1;
    if (!leaf && dec_depth >= StackDepth) return 1'b1;
    idx = dec_free;
    dec_free++;
    dec_nodes[idx].is_leaf = leaf;
    dec_nodes[idx].sym     = sym;
    dec_nodes[idx].left    = '0;
    dec_nodes[idx].right   = '0;
    if (dec_depth > 0) begin
      if (!dec_stack[dec_depth-1].left_done) begin
        dec_nodes[dec_stack[dec_depth-1].node].left = idx[NodeW-1:0];
        dec_stack[dec_depth-1].left_done = 1'b1;
      end else begin
        dec_nodes[dec_stack[dec_depth-1].node].right = idx[NodeW-1:0];
        dec_depth--;
      end
    end
    if (!leaf) begin
      dec_stack[dec_depth].node      = idx[NodeW-1:0];
      dec_stack[dec_depth].left_done = 1'b0;
      dec_depth++;
    end else if (dec_depth == 0) begin
      if (idx == 0) return 1'b1;
      dec_phase = PhData;
      dec_walk  = 0;
    end
    return 1'b0;
  endfunction

  task automatic decode_word(input in_word_t w);
    logic [7:0]  b;
    logic [3:0]  d;
    int unsigned nx;
    out_word_t   r;
    b = w.data_byte;
    if (w.start_req) begin
      dec_phase = PhHeader; dec_left = '0; dec_leaf_pend = 1'b0;
      dec_free = 0; dec_depth = 0; dec_walk = 0;
    end
    case (dec_phase)
      PhHeader: begin
        if (b >= CharZero && b <= CharNine) begin
          d = 4'(b - CharZero);
          if (dec_left > (CountMax - d) / 10) dec_left = CountMax;
          else dec_left = dec_left * 10 + d;
        end else if (b == CharL) begin
          dec_phase = PhTree; dec_leaf_pend = 1'b1;
        end else if (b == CharI) begin
          dec_phase = PhTree;
          if (decoder_add_node(1'b0, 8'h00)) expected_syms.push_back(error_word());
        end
      end
      PhTree: begin
        if (dec_leaf_pend) begin
          dec_leaf_pend = 1'b0;
          if (decoder_add_node(1'b1, b)) expected_syms.push_back(error_word());
        end else if (b == CharL) begin
          dec_leaf_pend = 1'b1;
        end else if (decoder_add_node(1'b0, 8'h00)) begin
          expected_syms.push_back(error_word());
        end
      end
      PhData: begin
        for (int i = 7; i >= 0; i--) begin
          if (dec_left == 0) break;
          nx = b[i] ? dec_nodes[dec_walk].right : dec_nodes[dec_walk].left;
          dec_walk = nx % NodeSlots;
          if (dec_nodes[dec_walk].is_leaf) begin
            dec_left--;
            r.symbol = dec_nodes[dec_walk].sym;
            r.last   = (dec_left == 0);
            r.status = 1'b0;
            expected_syms.push_back(r);
            dec_walk = 0;
          end
        end
        if (dec_left == 0) dec_phase = PhDone;
      end
      default: ;
    endcase
  endtask

  // driver: offer words from the queue, with random gaps
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_word(in_data_i);
        words_sent++;
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled word
      end else if (send_gap > 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        if (!quiet_tail && $urandom_range(0, 9) == 0) begin
          send_gap   <= $urandom_range(0, 11);
          in_valid_i <= 1'b0;
        end else begin
          in_data_i  <= pending_words.pop_front();
          in_valid_i <= 1'b1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: check accepted symbols and throttle the output
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        syms_seen++;
        if (expected_syms.size() == 0) begin
          report_mismatch("unexpected word", out_data_o, '0);
        end else if (out_data_o !== expected_syms[0]) begin
          report_mismatch("field", out_data_o, expected_syms[0]);
          void'(expected_syms.pop_front());
        end else begin
          void'(expected_syms.pop_front());
        end
      end
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        stall_left  <= $urandom_range(0, 11);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input bit st = 1'b0);
    in_word_t w;
    w.start_req = st;
    w.data_byte = b;
    pending_words.push_back(w);
  endtask

  // emit a random tree in preorder, recording leaf codes
  task automatic emit_tree(input int leaves, input logic [7:0] prefix [$]);
    int left_n;
    if (leaves <= 1) begin
      push_byte(CharL);
      leaf_syms.push_back(8'($urandom_range(0, 255)));
      push_byte(leaf_syms[$]);
      code_bits[leaf_syms.size()-1] = prefix;
      return;
    end
    push_byte($urandom_range(0, 1) ? CharI : 8'($urandom_range(0, 255) & 8'hF0 | 8'h01));
    left_n = $urandom_range(1, leaves - 1);
    emit_tree(left_n, {prefix, 8'd0});
    emit_tree(leaves - left_n, {prefix, 8'd1});
  endtask

  // one well-formed file: count, tree, packed code bits, optional pad
  task automatic push_file(input int leaves, input int count);
    logic [7:0] bits [$];
    logic [7:0] pre [$];
    logic [7:0] acc;
    string      s;
    int         k;
    leaf_syms.delete();
    s = $sformatf("%0d", count);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == 0);
    emit_tree(leaves, pre);
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, leaves - 1);
      for (int j = 0; j < code_bits[k].size(); j++) bits.push_back(code_bits[k][j]);
    end
    while (bits.size() % 8 != 0) bits.push_back(8'($urandom_range(0, 1)));
    for (int i = 0; i < bits.size(); i += 8) begin
      acc = '0;
      for (int j = 0; j < 8; j++) acc = {acc[6:0], bits[i+j][0]};
      push_byte(acc);
    end
    if ($urandom_range(0, 2) == 0) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drain();
    while (pending_words.size() > 0 || in_valid_i || expected_syms.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    error_count = 0; words_sent = 0; syms_seen = 0;
    quiet_tail = 1'b0; hold_off_req = 1'b0;
    dec_phase = PhHeader; dec_left = '0; dec_leaf_pend = 1'b0;
    dec_free = 0; dec_depth = 0; dec_walk = 0;
    repeat (6) @(posedge clk_i);
    rst_ni = 1'b1;

    // directed: two-leaf file with noise in the header and all-ones/zeros symbols
    push_byte(8'h00, 1'b1); push_byte(8'hFF); push_byte("3");
    push_byte(CharI); push_byte(CharL); push_byte(8'h00); push_byte(CharL); push_byte(8'hFF);
    push_byte(8'h5F);
    // one-leaf tree is an error; following bytes ignored
    push_byte("2", 1'b1); push_byte(CharL); push_byte(8'hAA); push_byte(8'h00);
    // zero count, then count saturation
    push_byte("0", 1'b1); push_byte(CharI); push_byte(CharL); push_byte(8'h11);
    push_byte(CharL); push_byte(8'h22); push_byte(8'hFF);
    for (int i = 0; i < 11; i++) push_byte("9", i == 0);
    push_byte(CharL); push_byte(8'hC3);
    wait_drain();

    // stack overflow: many internal nodes
    push_byte("1", 1'b1);
    for (int i = 0; i < 260; i++) push_byte(CharI);
    wait_drain();

    // receiver holds off while a long file keeps coming
    push_file(8, 40);
    hold_off_req = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off_req = 1'b0;
    wait_drain();

    while (words_sent < 430) begin
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < 6; i++) push_byte(8'($urandom_range(0, 255)), i == 0);
      end else if ($urandom_range(0, 9) == 0) begin
        push_byte("4", 1'b1); push_byte(CharI); push_byte(CharL); push_byte(8'h7E);
      end else begin
        push_file($urandom_range(2, 12), $urandom_range(1, 20));
      end
      if (words_sent > 370) quiet_tail = 1'b1;
      wait_drain();
    end
    $display("Sent %0d bytes over good, broken and noise files; checked %0d symbols.",
             words_sent, syms_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### huffman_stream_decoder_top.f
src/hsd_pkg.sv
src/hsd_ctrl.sv
src/hsd_dpath.sv
src/huffman_stream_decoder_top.sv
tb/sv/huffman_stream_decoder_top_test.sv
